// File: hdl/ffcc_pkg.sv
// ----------------------------------------------------------------------------
// First-fit conflict coloring package
// Shared widths, capacity constants and the item and result types.
// ----------------------------------------------------------------------------
package ffcc_pkg;

   localparam int MAX_ITEMS    = 32;
   localparam int GROUP_SLOTS  = 32;
   localparam int SET_CAPACITY = (MAX_ITEMS > GROUP_SLOTS) ? GROUP_SLOTS : MAX_ITEMS;
   localparam int MASK_W       = 32;
   localparam int IDX_W        = 5;
   localparam int CNT_W        = 6;

   typedef struct packed {
      logic [MASK_W-1:0] conflict_mask;
      logic              new_set;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0] item_index;
      logic [IDX_W-1:0] group_index;
      logic [CNT_W-1:0] groups_used;
      logic             overflow;
   } result_type;

endpackage

// File: hdl/ffcc_queue.sv
// ----------------------------------------------------------------------------
// First-fit conflict coloring input queue
// Two-entry queue that takes input words and hands them to the group search.
// ----------------------------------------------------------------------------
module ffcc_queue (
   input  logic              clock,
   input  logic              reset,
   input  ffcc_pkg::item_type in_item,
   input  logic              in_valid,
   output logic              in_ready,
   output ffcc_pkg::item_type out_item,
   output logic              out_valid,
   input  logic              out_ready
);
   import ffcc_pkg::*;

   item_type    q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_ready  = !reset && (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: hdl/ffcc_search.sv
// ----------------------------------------------------------------------------
// First-fit conflict coloring group search
// Scans the open groups one per cycle and places the item in the first group
// that holds none of its conflicts, or opens a new group; a full set gives an overflow result.
// ----------------------------------------------------------------------------
module ffcc_search (
   input  logic                clock,
   input  logic                reset,
   input  ffcc_pkg::item_type  in_item,
   input  logic                in_valid,
   output logic                in_ready,
   output ffcc_pkg::result_type out_result,
   output logic                out_valid,
   input  logic                out_ready
);
   import ffcc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);

   logic              state_ff, state_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]  items_ff, items_in;
   logic [CNT_W-1:0]  open_ff, open_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   result_type        result_ff, result_in;
   logic              valid_ff, valid_in;
   logic [MASK_W-1:0] members_ff [GROUP_SLOTS];

   logic              mem_we;
   logic [IDX_W-1:0]  mem_addr;
   logic [MASK_W-1:0] mem_data;
   logic              out_free;
   logic [MASK_W-1:0] cur_group;
   logic [MASK_W-1:0] item_bit;

   assign in_ready   = (state_ff == ST_IDLE);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_free   = !valid_ff || out_ready;
   assign cur_group  = members_ff[scan_ff[IDX_W-1:0]];
   assign item_bit   = MASK_W'(1) << items_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      mask_in   = mask_ff;
      items_in  = items_ff;
      open_in   = open_ff;
      scan_in   = scan_ff;
      result_in = result_ff;
      valid_in  = valid_ff && !out_ready;
      mem_we    = 1'b0;
      mem_addr  = scan_ff[IDX_W-1:0];
      mem_data  = cur_group | item_bit;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               mask_in  = in_item.conflict_mask;
               scan_in  = '0;
               state_in = ST_SEARCH;
               if (in_item.new_set) begin
                  items_in = '0;
                  open_in  = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (items_ff >= CAP_CNT) begin
               if (out_free) begin
                  result_in.item_index  = '0;
                  result_in.group_index = '0;
                  result_in.groups_used = open_ff;
                  result_in.overflow    = 1'b1;
                  valid_in              = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else if (scan_ff == open_ff) begin
               if (out_free) begin
                  mem_we                = 1'b1;
                  mem_addr              = open_ff[IDX_W-1:0];
                  mem_data              = item_bit;
                  result_in.item_index  = items_ff[IDX_W-1:0];
                  result_in.group_index = open_ff[IDX_W-1:0];
                  result_in.groups_used = open_ff + CNT_W'(1);
                  result_in.overflow    = 1'b0;
                  open_in               = open_ff + CNT_W'(1);
                  items_in              = items_ff + CNT_W'(1);
                  valid_in              = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else if ((cur_group & mask_ff) == '0) begin
               if (out_free) begin
                  mem_we                = 1'b1;
                  result_in.item_index  = items_ff[IDX_W-1:0];
                  result_in.group_index = scan_ff[IDX_W-1:0];
                  result_in.groups_used = open_ff;
                  result_in.overflow    = 1'b0;
                  items_in              = items_ff + CNT_W'(1);
                  valid_in              = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         items_ff <= '0;
         open_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         items_ff <= items_in;
         open_ff  <= open_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      scan_ff   <= scan_in;
      result_ff <= result_in;
      if (mem_we) begin
         members_ff[mem_addr] <= mem_data;
      end
   end

endmodule

// File: hdl/first_fit_conflict_coloring.sv
// A result word passes the input queue, the search's item register and the result
// register, plus one search step for every open group rejected, and waits while the receiver stalls.
// The search takes no new word until its result is registered; it reads one group
// mask of the member table per cycle. A two-entry input queue takes words while a search runs.
// Reset clears the counters, the queue and the result valid flag; a group's mask
// is overwritten when the group is opened, so the member table needs no clearing.
// ----------------------------------------------------------------------------
// First-fit conflict coloring
// Greedy first-fit grouping of a stream of items with conflict masks.
// ----------------------------------------------------------------------------
module first_fit_conflict_coloring (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // conflict_mask[31:0]
   input  logic        req_tuser,  // new_set
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // item_index[4:0], group_index[9:5], groups_used[15:10]
   output logic        rsp_tuser   // overflow
);
   import ffcc_pkg::*;

   item_type   req_item;
   item_type   queued_item;
   logic       queued_valid;
   logic       queued_ready;
   result_type result;

   assign req_item.conflict_mask = req_tdata;
   assign req_item.new_set       = req_tuser;

   ffcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (req_item),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_item  (queued_item),
      .out_valid (queued_valid),
      .out_ready (queued_ready)
   );

   ffcc_search u_search (
      .clock      (clock),
      .reset      (reset),
      .in_item    (queued_item),
      .in_valid   (queued_valid),
      .in_ready   (queued_ready),
      .out_result (result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {result.groups_used, result.group_index, result.item_index};
   assign rsp_tuser = result.overflow;

`ifndef SYNTHESIS
   a_group_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> ({1'b0, rsp_tdata[9:5]} < rsp_tdata[15:10]))
      else $error("placed group is not among the open groups");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[9:0] == 10'd0))
      else $error("overflow result carries nonzero indices");

   a_groups_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:10] <= 6'(SET_CAPACITY)))
      else $error("more groups open than the set can hold");

   a_groups_vs_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[15:10] <= {1'b0, rsp_tdata[4:0]} + 6'd1))
      else $error("more groups open than items placed");
`endif

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// First-fit conflict coloring testbench
// Streams items with conflict masks into the block and compares every result
// word with a greedy first-fit coloring kept in the bench. Short directed
// runs cover the extreme masks, the self and forward conflict bits, a full
// set with overflow and a long receiver hold-off. Random sets then run under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ffcc_pkg::*;

   localparam int STALL_LIMIT = 10000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // conflict_mask[31:0]
   logic        req_tuser  = 1'b0;  // new_set
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;  // item_index[4:0], group_index[9:5], groups_used[15:10]
   logic        rsp_tuser;  // overflow

   logic [MASK_W-1:0] member_masks [GROUP_SLOTS];
   logic [CNT_W-1:0]  assigned_count = '0;
   logic [CNT_W-1:0]  opened_groups  = '0;

   result_type pending_colorings [$];

   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int hold_off_request = 0;
   int hold_off_left    = 0;
   int stall_cycles     = 0;
   int mismatch_count   = 0;
   int words_sent       = 0;
   int results_checked  = 0;
   int overflow_words   = 0;
   int sets_started     = 0;
   int widest_coloring  = 0;

   first_fit_conflict_coloring uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type predict_coloring(input logic [MASK_W-1:0] mask,
                                                   input logic fresh);
      result_type outcome;
      int         g;
      int         chosen;
      outcome = '0;
      if (fresh) begin
         for (g = 0; g < GROUP_SLOTS; g++) begin
            member_masks[g] = '0;
         end
         assigned_count = '0;
         opened_groups  = '0;
         sets_started++;
      end
      if (assigned_count >= SET_CAPACITY) begin
         outcome.groups_used = opened_groups;
         outcome.overflow    = 1'b1;
         overflow_words++;
         return outcome;
      end
      chosen = opened_groups;
      for (g = 0; g < opened_groups; g++) begin
         if ((member_masks[g] & mask) == '0) begin
            chosen = g;
            break;
         end
      end
      if (chosen == opened_groups) begin
         member_masks[chosen] = '0;
         opened_groups = opened_groups + CNT_W'(1);
      end
      member_masks[chosen][assigned_count[IDX_W-1:0]] = 1'b1;
      outcome.item_index  = assigned_count[IDX_W-1:0];
      outcome.group_index = chosen[IDX_W-1:0];
      outcome.groups_used = opened_groups;
      assigned_count = assigned_count + CNT_W'(1);
      if (int'(opened_groups) > widest_coloring) widest_coloring = int'(opened_groups);
      return outcome;
   endfunction

   task automatic send_word(input logic [MASK_W-1:0] mask, input logic fresh);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mask;
      req_tuser  <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_colorings.insert(pending_colorings.size(), predict_coloring(mask, fresh));
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_colorings.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_set(input int length);
      logic [MASK_W-1:0] mask;
      logic              fresh;
      int                i;
      for (i = 0; i < length; i++) begin
         case ($urandom_range(3))
            0: mask = $urandom;
            1: mask = $urandom & $urandom;
            2: mask = $urandom & $urandom & $urandom;
            default: mask = 32'd1 << $urandom_range(31);
         endcase
         if ($urandom_range(3) == 0 && i < 32) begin
            mask = mask & ((32'd1 << i) - 32'd1);
         end
         fresh = (i == 0);
         if (i != 0 && $urandom_range(99) < 4) fresh = 1'b1;
         send_word(mask, fresh);
      end
   endtask

   task automatic test_field_extremes();
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0008, 1'b0);
      send_word(32'hFFFF_FFF0, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0022, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      wait_drained();
   endtask

   task automatic test_full_set();
      int i;
      send_word(32'hFFFF_FFFF, 1'b1);
      for (i = 1; i < SET_CAPACITY + 2; i++) begin
         send_word(32'hFFFF_FFFF, 1'b0);
      end
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h5555_AAAA, 1'b1);
      wait_drained();
   endtask

   task automatic test_receiver_hold_off();
      hold_off_request = 1500;
      send_random_set(40);
      send_random_set(20);
      wait_drained();
   endtask

   task automatic test_random_mix(input int idle_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target = words_sent + count;
      while (words_sent < target) begin
         if ($urandom_range(5) == 0) send_random_set($urandom_range(32, 38));
         else send_random_set($urandom_range(1, 31));
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_off_request != 0) begin
         hold_off_left    = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_colorings.size() == 0) begin
            $display("%0t ns: result word expected none, got tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_colorings.pop_front();
            check_field("item_index", int'(want.item_index), int'(rsp_tdata[4:0]));
            check_field("group_index", int'(want.group_index), int'(rsp_tdata[9:5]));
            check_field("groups_used", int'(want.groups_used), int'(rsp_tdata[15:10]));
            check_field("overflow", int'(want.overflow), int'(rsp_tuser));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_full_set();
      test_receiver_hold_off();
      test_random_mix(0, 0, 225);
      test_random_mix(60, 0, 225);
      test_random_mix(0, 60, 225);
      test_random_mix(22, 22, 225);
      recv_stall_pct = 0;
      wait_drained();
      repeat (60) @(posedge clock);
      if (pending_colorings.size() != 0) begin
         $display("%0t ns: %0d colorings expected, none arrived",
                  $time, pending_colorings.size());
         mismatch_count++;
      end
      $display("Sent %0d words in %0d sets; checked %0d results, %0d of them overflow.",
               words_sent, sets_started, results_checked, overflow_words);
      $display("Widest coloring used %0d groups; %0d mismatches.",
               widest_coloring, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/ffcc_pkg.sv
hdl/ffcc_queue.sv
hdl/ffcc_search.sv
hdl/first_fit_conflict_coloring.sv
bench/testbench.sv
